@@ sv/spq_pkg.sv @@
// spq_pkg: shared types and codes for the stable priority queue.
// Used by spq_cell and stable_priority_queue; depends on nothing.
`timescale 1ns / 1ps

package spq_pkg;

   // command codes on req_op
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // status codes on rsp_status
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_RANGE     = 2'd1;
   localparam logic [1:0] ST_EMPTY_POP = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // configuration register indexes
   localparam logic [7:0] CSR_MIN_PRIORITY = 8'd0;
   localparam logic [7:0] CSR_MAX_PRIORITY = 8'd1;

   // one stored entry
   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] payload;
   } entry_type;

   // command broadcast to every cell
   typedef struct packed {
      logic        ins;     // insert that passed range and full checks
      logic        pop;     // pop on a non-empty queue
      logic [7:0]  prio;
      logic [15:0] payload;
   } cmd_type;

endpackage

@@ sv/spq_cell.sv @@
// spq_cell: one slot of the sorted shift-register queue.
// Depends on spq_pkg; instantiated once per slot by stable_priority_queue.
`timescale 1ns / 1ps

module spq_cell #(
   parameter int IDX = 0,
   parameter int CW  = 5
) (
   input  logic              clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic [CW-1:0]     count,      // occupancy before the command
   input  spq_pkg::entry_type left_entry,
   input  logic              left_mv,    // left slot moves on insert
   input  spq_pkg::entry_type right_entry,
   output spq_pkg::entry_type entry,     // current contents
   output spq_pkg::entry_type entry_next,
   output logic              mv          // this slot moves on insert
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      occupied;

   // slot is live when it lies below the count
   assign occupied = (count > CW'(IDX));

   // new item lands at or ahead of this slot: slot empty or strictly larger
   assign mv = !occupied || (entry_ff.prio > cmd.prio);

   // next contents: shift right on insert, shift left on pop, else hold
   always_comb begin
      entry_in = entry_ff;
      if (cmd.ins && mv) begin
         if (left_mv) begin
            entry_in = left_entry;
         end else begin
            entry_in.prio    = cmd.prio;
            entry_in.payload = cmd.payload;
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

@@ sv/stable_priority_queue.sv @@
// stable_priority_queue: sorted, stable, bounded priority queue top level.
// Depends on spq_pkg and spq_cell (one cell per slot).
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+---------------------------------------
//   req      | start & !busy              | req_op, req_priority_req, req_payload
//   rsp      | rsp_valid, one cycle       | status, count, is_empty, head entry
//   csr      | csr_valid & csr_ready      | csr_index, csr_data
//
// One command per cycle while busy is low; its result appears on the cycle after acceptance.
// All slots compare against the new priority in parallel and shift by one
// to their neighbor in the same cycle, so the cell row sets the one-cycle rate.
// busy is high during reset and until the first clock edge after reset is released; otherwise low.
// Reset empties the queue and restores min 0 / max 255. The receiver cannot
// stall, so rsp is never held.
`timescale 1ns / 1ps

module stable_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_op,
   input  logic [7:0]  req_priority_req,
   input  logic [15:0] req_payload,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_count,
   output logic        rsp_is_empty,
   output logic [7:0]  rsp_head_priority,
   output logic [15:0] rsp_head_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [7:0]  csr_data
);
   import spq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    min_prio_ff, max_prio_ff;
   logic          busy_ff;
   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff, status_in;
   logic [4:0]    rsp_count_ff;
   logic          rsp_is_empty_ff;
   entry_type     rsp_head_ff, head_in;
   logic          accept, in_range, full;
   cmd_type       cmd;

   entry_type     cell_q    [DEPTH];
   entry_type     cell_next [DEPTH];
   logic          cell_mv   [DEPTH];

   assign accept   = start && !busy_ff;
   assign in_range = (req_priority_req >= min_prio_ff) && (req_priority_req <= max_prio_ff);
   assign full     = (count_ff == CW'(DEPTH));

   // decode the command and its status
   always_comb begin
      cmd.ins     = 1'b0;
      cmd.pop     = 1'b0;
      cmd.prio    = req_priority_req;
      cmd.payload = req_payload;
      status_in   = ST_OK;
      count_in    = count_ff;
      if (accept) begin
         case (req_op)
            OP_INSERT: begin
               if (!in_range) begin
                  status_in = ST_RANGE;
               end else if (full) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.ins  = 1'b1;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_POP: begin
               if (count_ff == '0) begin
                  status_in = ST_EMPTY_POP;
               end else begin
                  cmd.pop  = 1'b1;
                  count_in = count_ff - CW'(1);
               end
            end
            OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   // row of cells, each talking only to its neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_e, right_e;
      logic      left_m;
      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_m = 1'b0;
      end else begin : g_mid
         assign left_e = cell_q[i-1];
         assign left_m = cell_mv[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = cell_q[i+1];
      end
      spq_cell #(
         .IDX(i),
         .CW (CW)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .count      (count_ff),
         .left_entry (left_e),
         .left_mv    (left_m),
         .right_entry(right_e),
         .entry      (cell_q[i]),
         .entry_next (cell_next[i]),
         .mv         (cell_mv[i])
      );
   end

   // head after the command, zero when empty
   assign head_in = (count_in == '0) ? '0 : cell_next[0];

   // control, config and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         count_ff     <= '0;
         min_prio_ff  <= 8'd0;
         max_prio_ff  <= 8'd255;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
         if (csr_valid) begin
            if (csr_index == CSR_MIN_PRIORITY) begin
               min_prio_ff <= csr_data;
            end else if (csr_index == CSR_MAX_PRIORITY) begin
               max_prio_ff <= csr_data;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff   <= status_in;
         rsp_count_ff    <= 5'(count_in);
         rsp_is_empty_ff <= (count_in == '0);
         rsp_head_ff     <= head_in;
      end
   end

   assign busy              = busy_ff;
   // register writes are taken on any edge outside reset
   assign csr_ready         = !reset;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_count         = rsp_count_ff;
   assign rsp_is_empty      = rsp_is_empty_ff;
   assign rsp_head_priority = rsp_head_ff.prio;
   assign rsp_head_payload  = rsp_head_ff.payload;

   // checks
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted item produced no result");
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_valid)
      else $error("result without accepted item");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("count above depth");
   a_empty_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (count_ff == '0)))
      else $error("empty flag disagrees with count");
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> (count_ff == CW'(DEPTH)))
      else $error("full status while not full");

endmodule
